### rtl/length_prefixed_message_deframer_assert.svh
// Assertion macros for the length-prefixed message deframer.
// Depends on nothing; included inside module bodies that assert.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH

// clocked assertion, disabled while reset is low
`define LPMD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// same, on the usual clock and reset names
`define LPMD_ASSERT(lbl, prop, msg) \
  `LPMD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/lpmd_pkg.sv
// Types and constants for the length-prefixed message deframer.
// No dependencies; imported by length_prefixed_message_deframer.
package lpmd_pkg;

  localparam logic [31:0] MaxLenReset  = 32'd1048576;
  localparam logic [31:0] HdrAfterLen  = 32'd6;
  localparam logic [31:0] LenLastPos   = 32'd3;
  localparam logic [31:0] HdrLastPos   = 32'd5;
  localparam logic [31:0] PosStream    = 32'd0;
  localparam logic [31:0] PosFunction  = 32'd1;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } lpmd_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  stream_code;
    logic [7:0]  function_code;
    logic [31:0] transaction_id;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } lpmd_out_t;

endpackage

### rtl/length_prefixed_message_deframer.sv
// Length-prefixed message deframer: takes one byte (or a clear) per request and
// returns header, payload-byte and error results. One request per clock cycle
// when the result side keeps up; a single output register sits between the
// per-byte frame state machine and the result channel, so a waiting result
// only stalls input when it is not being taken in the same cycle. The result
// is registered, appearing in the cycle after its request is accepted. Frames:
// 4-byte big-endian length, stream byte, function byte, 4-byte transaction id,
// then length-6 payload bytes. A length below 6 or above the configured max_len_q
// gives one error result; afterwards data bytes are dropped until a clear
// request. Depends on lpmd_pkg and the assertion header.
module length_prefixed_message_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpmd_pkg::lpmd_in_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lpmd_pkg::lpmd_out_t out_rsp_o
);
  import lpmd_pkg::*;
  `include "length_prefixed_message_deframer_assert.svh"

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic [31:0] plen_q, plen_d;
  logic [7:0]  stream_q, stream_d;
  logic [7:0]  func_q, func_d;
  logic [31:0] tid_q, tid_d;
  logic [31:0] max_len_q;
  logic        out_valid_q, out_valid_d;
  lpmd_out_t   out_q;
  lpmd_out_t   res;
  logic        res_vld;
  logic        acc;
  logic [31:0] pos_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign acc         = in_valid_i & ~in_stall_o;
  assign pos_inc     = pos_q + 32'd1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_d    = len_q;
    plen_d   = plen_q;
    stream_d = stream_q;
    func_d   = func_q;
    tid_d    = tid_q;
    res_vld  = 1'b0;
    res      = '0;
    if (acc) begin
      if (in_req_i.mode == MODE_CLEAR) begin
        phase_d = PH_LENGTH;
        pos_d   = '0;
      end else begin
        case (phase_q)
          PH_LENGTH: begin
            len_d = {len_q[23:0], in_req_i.data_byte};
            if (pos_q == LenLastPos) begin
              pos_d = '0;
              if (len_d < HdrAfterLen || len_d > max_len_q) begin
                phase_d  = PH_ERROR;
                res_vld  = 1'b1;
                res.kind = KIND_ERROR;
              end else begin
                phase_d = PH_HEADER;
                plen_d  = len_d - HdrAfterLen;
              end
            end else begin
              pos_d = pos_inc;
            end
          end
          PH_HEADER: begin
            if (pos_q == PosStream) begin
              stream_d = in_req_i.data_byte;
            end else if (pos_q == PosFunction) begin
              func_d = in_req_i.data_byte;
            end else begin
              tid_d = {tid_q[23:0], in_req_i.data_byte};
            end
            if (pos_q == HdrLastPos) begin
              pos_d              = '0;
              res_vld            = 1'b1;
              res.kind           = KIND_HEADER;
              res.stream_code    = stream_d;
              res.function_code  = func_d;
              res.transaction_id = tid_d;
              res.payload_length = plen_q;
              res.frame_end      = (plen_q == '0);
              phase_d            = (plen_q == '0) ? PH_LENGTH : PH_PAYLOAD;
            end else begin
              pos_d = pos_inc;
            end
          end
          PH_PAYLOAD: begin
            res_vld            = 1'b1;
            res.kind           = KIND_PAYLOAD;
            res.stream_code    = stream_q;
            res.function_code  = func_q;
            res.transaction_id = tid_q;
            res.payload_length = plen_q;
            res.payload_byte   = in_req_i.data_byte;
            res.frame_end      = (pos_inc == plen_q);
            if (pos_inc == plen_q) begin
              phase_d = PH_LENGTH;
              pos_d   = '0;
            end else begin
              pos_d = pos_inc;
            end
          end
          default: begin
            // error: drop data bytes until a clear
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (!in_stall_o) begin
      out_valid_d = acc & res_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LENGTH;
      pos_q       <= '0;
      max_len_q   <= MaxLenReset;
      out_valid_q <= 1'b0;
      stream_q    <= '0;
      func_q      <= '0;
      tid_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      stream_q    <= stream_d;
      func_q      <= func_d;
      tid_q       <= tid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    plen_q <= plen_d;
    if (acc && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `LPMD_ASSERT(a_err_fields_zero,
    (out_valid_q && out_q.kind == KIND_ERROR) |->
      (out_q.stream_code == '0 && out_q.transaction_id == '0 &&
       out_q.payload_length == '0 && out_q.frame_end == 1'b0),
    "error result carries nonzero fields")
  `LPMD_ASSERT(a_clear_restarts,
    (acc && in_req_i.mode == MODE_CLEAR) |=> (phase_q == PH_LENGTH && pos_q == '0),
    "clear did not restart framing")
  `LPMD_ASSERT(a_error_sticky,
    (acc && in_req_i.mode == MODE_DATA && phase_q == PH_ERROR) |=>
      (phase_q == PH_ERROR && !(out_valid_q && out_q.kind != KIND_ERROR &&
       $past(!out_valid_q || !out_stall_i))),
    "data byte left error phase or produced a result")
  `LPMD_ASSERT(a_end_returns_to_length,
    (acc && res_vld && res.frame_end) |=> (phase_q == PH_LENGTH && pos_q == '0),
    "frame end did not return to length phase")
  `LPMD_ASSERT(a_short_counts_bounded,
    (phase_q == PH_LENGTH || phase_q == PH_HEADER) |-> (pos_q <= HdrLastPos),
    "header byte position out of range")

endmodule

### verif/tb_length_prefixed_message_deframer.sv
`timescale 1ns / 100ps
// Testbench for length_prefixed_message_deframer: streams byte and clear requests,
// predicts header, payload and error results, and checks them in order.
// Depends on lpmd_pkg and the deframer RTL.
module tb_length_prefixed_message_deframer;
  import lpmd_pkg::*;

  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned LongHoldAt     = 150;
  localparam int unsigned LongHoldCycles = 60;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  lpmd_in_t    in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  lpmd_out_t   out_rsp_o;

  lpmd_in_t  tx_bytes[$];
  lpmd_out_t due_results[$];

  // frame tracker
  logic [31:0] len_limit;
  phase_e      fr_phase;
  logic [31:0] fr_pos;
  logic [31:0] fr_len;
  logic [7:0]  hd_stream;
  logic [7:0]  hd_func;
  logic [31:0] hd_tid;

  int unsigned n_in_taken;
  int unsigned idle_run;
  int unsigned mismatches = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned in_gap;
  int unsigned out_hold;
  logic        long_hold_done;
  logic [31:0] cur_limit = MaxLenReset;

  length_prefixed_message_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic string show_rsp(input lpmd_out_t r);
    return $sformatf("kind %0d stream %02h function %02h tid %08h len %0d byte %02h end %0b",
                     r.kind, r.stream_code, r.function_code, r.transaction_id,
                     r.payload_length, r.payload_byte, r.frame_end);
  endfunction

  function automatic lpmd_out_t framed_rsp(input kind_e k, input logic [7:0] b,
                                           input logic last);
    lpmd_out_t o;
    o.kind           = k;
    o.stream_code    = hd_stream;
    o.function_code  = hd_func;
    o.transaction_id = hd_tid;
    o.payload_length = fr_len - HdrAfterLen;
    o.payload_byte   = b;
    o.frame_end      = last;
    return o;
  endfunction

  function automatic void deframe_byte(input lpmd_in_t r);
    lpmd_out_t o;
    logic      last;
    o = '0;
    if (r.mode == MODE_CLEAR) begin
      fr_phase = PH_LENGTH;
      fr_pos   = '0;
      fr_len   = '0;
      return;
    end
    case (fr_phase)
      PH_LENGTH: begin
        fr_len = {fr_len[23:0], r.data_byte};
        fr_pos = fr_pos + 1;
        if (fr_pos > LenLastPos) begin
          fr_pos = '0;
          if (fr_len < HdrAfterLen || fr_len > len_limit) begin
            fr_phase = PH_ERROR;
            o.kind   = KIND_ERROR;
            due_results.push_back(o);
          end else begin
            fr_phase = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if (fr_pos == PosStream) hd_stream = r.data_byte;
        else if (fr_pos == PosFunction) hd_func = r.data_byte;
        else hd_tid = {hd_tid[23:0], r.data_byte};
        fr_pos = fr_pos + 1;
        if (fr_pos > HdrLastPos) begin
          fr_pos = '0;
          last   = (fr_len == HdrAfterLen);
          due_results.push_back(framed_rsp(KIND_HEADER, 8'h00, last));
          if (last) begin
            fr_phase = PH_LENGTH;
            fr_len   = '0;
          end else begin
            fr_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        fr_pos = fr_pos + 1;
        last   = (fr_pos == fr_len - HdrAfterLen);
        due_results.push_back(framed_rsp(KIND_PAYLOAD, r.data_byte, last));
        if (last) begin
          fr_phase = PH_LENGTH;
          fr_pos   = '0;
          fr_len   = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(input lpmd_out_t got);
    lpmd_out_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result with none due: %s", $realtime, show_rsp(got));
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind || got.stream_code !== want.stream_code ||
        got.function_code !== want.function_code ||
        got.transaction_id !== want.transaction_id ||
        got.payload_length !== want.payload_length ||
        got.payload_byte !== want.payload_byte || got.frame_end !== want.frame_end) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch", $realtime);
        $display("  expected %s", show_rsp(want));
        $display("  actual   %s", show_rsp(got));
      end
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      in_gap     <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (in_valid_i && $urandom_range(1, 100) <= in_idle_pct) begin
        in_valid_i <= 1'b0;
        in_gap     <= $urandom_range(0, 2);
      end else if (tx_bytes.size() != 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= tx_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result-side stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      out_hold       <= 0;
      long_hold_done <= 1'b0;
    end else if (out_hold != 0) begin
      out_stall_i <= 1'b1;
      out_hold    <= out_hold - 1;
    end else if (!long_hold_done && n_in_taken >= LongHoldAt) begin
      out_stall_i    <= 1'b1;
      out_hold       <= LongHoldCycles - 1;
      long_hold_done <= 1'b1;
    end else if ($urandom_range(1, 100) <= out_idle_pct) begin
      out_stall_i <= 1'b1;
      out_hold    <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor, tracker and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit  = MaxLenReset;
      fr_phase   = PH_LENGTH;
      fr_pos     = '0;
      fr_len     = '0;
      hd_stream  = '0;
      hd_func    = '0;
      hd_tid     = '0;
      due_results.delete();
      n_in_taken <= 0;
      idle_run   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_rsp_o);
      if (cfg_valid_i && cfg_ready_o) len_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(in_req_i);
        n_in_taken <= n_in_taken + 1;
      end
      if ((out_valid_o && !out_stall_i) || (cfg_valid_i && cfg_ready_o) ||
          (in_valid_i && !in_stall_o)) begin
        idle_run <= 0;
      end else if (idle_run >= StallLimit) begin
        $display("tb_length_prefixed_message_deframer: done, errors");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back({MODE_DATA, b});
  endtask

  task automatic push_clear();
    tx_bytes.push_back({MODE_CLEAR, any_byte()});
  endtask

  task automatic push_word(input logic [31:0] w);
    int i;
    for (i = 3; i >= 0; i--) push_byte(w[8*i +: 8]);
  endtask

  task automatic push_frame(input logic [31:0] flen_f, input logic [7:0] strm,
                            input logic [7:0] fcode, input logic [31:0] tid,
                            input int unsigned npay);
    push_word(flen_f);
    push_byte(strm);
    push_byte(fcode);
    push_word(tid);
    repeat (npay) push_byte(any_byte());
  endtask

  task automatic push_traffic(input int unsigned n);
    int unsigned goal;
    int unsigned sel;
    logic [31:0] plen;
    goal = tx_bytes.size() + n;
    while (tx_bytes.size() < goal) begin
      sel  = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      if (plen > cur_limit - HdrAfterLen) plen = cur_limit - HdrAfterLen;
      if (sel < 70) begin
        push_frame(plen + HdrAfterLen, any_byte(), any_byte(), $urandom(), plen);
      end else if (sel < 78) begin
        // rejected length, trailing bytes dropped until clear
        if (cur_limit == 32'hFFFF_FFFF || $urandom_range(0, 1) == 0)
          push_word($urandom_range(0, 5));
        else
          push_word(cur_limit + 1 + $urandom_range(0, 3));
        repeat ($urandom_range(0, 3)) push_byte(any_byte());
        push_clear();
      end else if (sel < 88) begin
        // frame cut short
        push_word(plen + HdrAfterLen);
        repeat ($urandom_range(0, plen + 5)) push_byte(any_byte());
        push_clear();
      end else if (sel < 93) begin
        push_clear();
      end else begin
        repeat ($urandom_range(1, 8)) push_byte(any_byte());
        push_clear();
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (tx_bytes.size() != 0 || in_valid_i || due_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_len_limit(input logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_limit = v;
    @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] m;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    in_idle_pct  = 15;
    out_idle_pct = 15;
    push_frame(HdrAfterLen, 8'hFF, 8'h00, 32'hFFFF_FFFF, 0);
    push_frame(HdrAfterLen + 1, 8'h00, 8'hFF, 32'h0000_0000, 1);
    push_word(32'd5);
    push_byte(8'hFF);
    push_clear();
    push_traffic(330);
    drain();

    set_len_limit(HdrAfterLen);
    in_idle_pct  = 30;
    out_idle_pct = 10;
    push_word(HdrAfterLen + 1);
    push_clear();
    push_frame(HdrAfterLen, any_byte(), any_byte(), $urandom(), 0);
    push_traffic(330);
    drain();

    set_len_limit(32'hFFFF_FFFF);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    push_frame(32'hFFFF_FFFF, any_byte(), any_byte(), $urandom(), 3);
    push_clear();
    push_word(32'd0);
    push_clear();
    push_traffic(330);
    drain();

    m = $urandom_range(6, 20);
    set_len_limit(m);
    in_idle_pct  = 40;
    out_idle_pct = 40;
    push_frame(m, any_byte(), any_byte(), $urandom(), m - HdrAfterLen);
    push_word(m + 1);
    push_clear();
    push_traffic(330);
    drain();

    set_len_limit(MaxLenReset);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    push_traffic(330);
    drain();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb_length_prefixed_message_deframer: done, clean");
    end else begin
      $display("tb_length_prefixed_message_deframer: done, errors");
    end
    $finish;
  end

endmodule
